### src/fpa_pkg.sv
// Shared types and constants for the fixed-partition first-fit allocator.
package fpa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int IDX_W          = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int OWNER_W  = 16;
    localparam int STATUS_W = 2;
    localparam int PIDX_W   = 4;
    localparam int ADDR_W   = 20;
    localparam int WASTE_W  = 14;
    localparam int PROD_W   = SIZE_W + WASTE_W;

    localparam logic [WASTE_W-1:0] WASTE_SCALE = WASTE_W'(10000);

    localparam logic [0:0] REG_PARTITION_SIZE  = 1'd0;
    localparam logic [0:0] REG_PARTITION_COUNT = 1'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic               busy;
        logic [OWNER_W-1:0] owner;
    } part_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        part_entry_t      data;
    } ram_wr_t;

endpackage

### src/fpa_part_ram.sv
// Partition table memory: one entry per partition, registered read, valid bits for reset.
module fpa_part_ram (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpa_pkg::ram_wr_t       wr,
    input  logic [fpa_pkg::IDX_W-1:0] rd_addr,
    output fpa_pkg::part_entry_t   rd_data
);
    import fpa_pkg::*;

    part_entry_t               mem_reg [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] valid_reg;
    part_entry_t               rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        // never-written entries read as free, no owner
        rd_data_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fpa_waste_div.sv
// Waste computation: (size - request) * 10000 / size, one quotient bit per cycle.
module fpa_waste_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fpa_pkg::SIZE_W-1:0]  psize,
    input  logic [fpa_pkg::SIZE_W-1:0]  req,
    output logic                        busy,
    output logic [fpa_pkg::WASTE_W-1:0] quotient
);
    import fpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_DIV
    } div_state_t;

    localparam int ITER_W = $clog2(WASTE_W + 1);

    div_state_t          state_reg;
    logic [SIZE_W-1:0]   diff_reg;
    logic [SIZE_W-1:0]   divisor_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [WASTE_W-1:0]  shift_reg;
    logic [ITER_W-1:0]   iter_reg;

    logic [SIZE_W:0]     trial;
    logic                qbit;

    // quotient stays below 2^14, so the top dividend bits start below the divisor
    assign trial = {rem_reg, shift_reg[WASTE_W-1]};
    assign qbit  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        diff_reg    <= psize - req;
                        divisor_reg <= psize;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(diff_reg) * PROD_W'(WASTE_SCALE);
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    rem_reg   <= prod_reg[PROD_W-1:WASTE_W];
                    shift_reg <= prod_reg[WASTE_W-1:0];
                    iter_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg   <= qbit ? SIZE_W'(trial - {1'b0, divisor_reg})
                                      : trial[SIZE_W-1:0];
                    shift_reg <= {shift_reg[WASTE_W-2:0], qbit};
                    iter_reg  <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(WASTE_W - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign quotient = shift_reg;

endmodule

### src/fixed_partition_first_fit_allocator.sv
// Top level of the fixed-partition first-fit allocator: command sequencer and result register.
//
// Usage:
//   Input stream (s_*): one command per transaction. s_tuser is the command
//   (0 allocate, 1 free by owner id); s_tdata carries request_size and
//   owner_to_free. Output stream (m_*): one result per command, in order.
//   Configuration: cfg_index 0 writes partition_size, 1 partition_count;
//   write only while no command is in flight.
// Sequencing:
//   One command at a time. The table is scanned from entry 0, one entry per
//   cycle, through the registered read of the table memory. In parallel the
//   waste divider runs (multiply, load, 14 quotient bits). The result is
//   registered once the scan and the divider are both done and the output
//   register is free; the next command is taken after that, once the
//   sequencer is back in idle.
// Reset: all partitions free, owner id counter at 1, partition_size 64,
//   partition_count 16. No clearing pass: per-entry valid bits cover it.
// Stall: the result waits in an output register while the next command is
//   accepted and processed; its completion waits while the register is full.
module fixed_partition_first_fit_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] owner_to_free
    input  logic        s_tuser,   // [0] command
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] status, [5:2] partition_index,
                                   // [25:6] start_address, [41:26] owner_id,
                                   // [55:42] waste_hundredths
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } seq_state_t;

    seq_state_t          state_reg;
    logic [SIZE_W-1:0]   psize_reg;
    logic [COUNT_W-1:0]  pcount_reg;
    logic [OWNER_W-1:0]  next_id_reg;

    logic                cmd_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic [OWNER_W-1:0]  who_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic                chk_valid_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    found_idx_reg;
    logic [OWNER_W-1:0]  found_owner_reg;

    logic                out_valid_reg;
    logic [55:0]         out_data_reg;

    logic [CNT_W-1:0]    n_sat;
    logic                issue;
    logic [IDX_W-1:0]    rd_addr;
    part_entry_t         rd_data;
    logic                hit;
    ram_wr_t             ram_wr;
    logic                accept;
    logic                div_busy;
    logic [WASTE_W-1:0]  div_q;
    logic                finish;

    logic [31:0]         idx_full;
    logic [31:0]         addr_full;
    logic [STATUS_W-1:0] res_status;
    logic [PIDX_W-1:0]   res_idx;
    logic [ADDR_W-1:0]   res_addr;
    logic [OWNER_W-1:0]  res_owner;
    logic [WASTE_W-1:0]  res_waste;

    // counts beyond the table depth saturate
    assign n_sat = (32'(pcount_reg) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                      : CNT_W'(pcount_reg);

    assign accept  = (state_reg == S_IDLE) && s_tvalid;
    assign issue   = (state_reg == S_SCAN) && (scan_reg < n_reg);
    assign rd_addr = scan_reg[IDX_W-1:0];

    // allocate wants a free entry that covers the request; free wants the owner
    always_comb
    begin
        if (cmd_reg == CMD_ALLOC)
        begin
            hit = !rd_data.busy && (psize_reg >= req_reg);
        end
        else
        begin
            hit = rd_data.busy && (rd_data.owner == who_reg);
        end
    end

    // write back the claimed or released entry in the cycle it is found
    always_comb
    begin
        ram_wr.en         = (state_reg == S_SCAN) && chk_valid_reg && hit;
        ram_wr.addr       = chk_idx_reg;
        ram_wr.data.busy  = (cmd_reg == CMD_ALLOC);
        ram_wr.data.owner = (cmd_reg == CMD_ALLOC) ? next_id_reg : '0;
    end

    fpa_part_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fpa_waste_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .psize    (psize_reg),
        .req      (s_tdata[15:0]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // result assembly; address always uses the current partition size
    assign idx_full  = 32'(found_idx_reg);
    assign addr_full = idx_full * 32'(psize_reg);

    always_comb
    begin
        if (found_reg)
        begin
            res_status = ST_OK;
            res_idx    = idx_full[PIDX_W-1:0];
            res_addr   = addr_full[ADDR_W-1:0];
            res_owner  = found_owner_reg;
            res_waste  = ((cmd_reg == CMD_ALLOC) && (req_reg != '0)) ? div_q : '0;
        end
        else
        begin
            res_status = (cmd_reg == CMD_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
            res_idx    = '0;
            res_addr   = '0;
            res_owner  = '0;
            res_waste  = '0;
        end
    end

    assign finish = (state_reg == S_DONE) && !div_busy && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            psize_reg     <= SIZE_W'(64);
            pcount_reg    <= COUNT_W'(16);
            next_id_reg   <= OWNER_W'(1);
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PARTITION_SIZE:  psize_reg  <= cfg_data[SIZE_W-1:0];
                    REG_PARTITION_COUNT: pcount_reg <= cfg_data[COUNT_W-1:0];
                    default:             ;
                endcase
            end

            if (m_tready && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg       <= s_tuser;
                        req_reg       <= s_tdata[15:0];
                        who_reg       <= s_tdata[31:16];
                        n_reg         <= n_sat;
                        scan_reg      <= '0;
                        chk_valid_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        // no active partitions: nothing to scan
                        state_reg     <= (n_sat == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scan_reg      <= scan_reg + CNT_W'(issue);
                    chk_valid_reg <= issue;
                    chk_idx_reg   <= rd_addr;
                    if (chk_valid_reg && hit)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= chk_idx_reg;
                        chk_valid_reg <= 1'b0;
                        if (cmd_reg == CMD_ALLOC)
                        begin
                            found_owner_reg <= next_id_reg;
                            // id 0 is never issued
                            next_id_reg <= (next_id_reg == '1) ? OWNER_W'(1)
                                                               : next_id_reg + 1'b1;
                        end
                        else
                        begin
                            found_owner_reg <= who_reg;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (chk_valid_reg && !issue)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        out_data_reg  <= {res_waste, res_owner, res_addr, res_idx, res_status};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
